// File: rtl/q15fc_pkg.sv
// q15fc_pkg: shared widths, codes and types for the Q15 full convolution block.
// No dependencies; every other file of the block imports this package.
`timescale 1ns / 1ps
`default_nettype none

package q15fc_pkg;

   localparam int MaxTapsDefault = 64;
   localparam int IndexWidth     = 6;
   localparam int ValueWidth     = 16;
   localparam int TapWidth       = 7;
   localparam int ProdWidth      = 32;
   localparam int SumWidth       = 39;
   localparam int QueueDepth     = 2;

   // operation field codes
   localparam logic OP_LOAD   = 1'b0;
   localparam logic OP_SAMPLE = 1'b1;

   typedef enum logic [1:0] {
      KIND_LOAD,
      KIND_SAMPLE,
      KIND_FINAL
   } cmd_kind_type;

   typedef struct packed {
      cmd_kind_type                 kind;
      logic [IndexWidth-1:0]        index;
      logic signed [ValueWidth-1:0] value;
   } cmd_type;

   typedef enum logic [1:0] {
      BACK_IDLE,
      BACK_RUN,
      BACK_FLUSH,
      BACK_EMIT
   } back_state_type;

endpackage

`default_nettype wire

// File: rtl/q15fc_if.sv
// q15fc_req_if / q15fc_rsp_if: valid/ready channels for the convolution block.
// Depends on q15fc_pkg for field widths.
`timescale 1ns / 1ps
`default_nettype none

interface q15fc_req_if import q15fc_pkg::*; ();
   logic                         valid;
   logic                         ready;
   logic                         operation;
   logic [IndexWidth-1:0]        coef_index;
   logic signed [ValueWidth-1:0] value;
   logic                         last_sample;

   modport source (output valid, operation, coef_index, value, last_sample, input ready);
   modport sink   (input valid, operation, coef_index, value, last_sample, output ready);
endinterface

interface q15fc_rsp_if import q15fc_pkg::*; ();
   logic                       valid;
   logic                       ready;
   logic signed [SumWidth-1:0] sum;
   logic                       last_output;

   modport source (output valid, sum, last_output, input ready);
   modport sink   (input valid, sum, last_output, output ready);
endinterface

`default_nettype wire

// File: rtl/q15fc_front.sv
// q15fc_front: accepts request transactions, classifies them and queues them.
// Depends on q15fc_pkg and q15fc_req_if.
`timescale 1ns / 1ps
`default_nettype none

module q15fc_front import q15fc_pkg::*; #(
   parameter int MAX_TAPS = MaxTapsDefault
) (
   input  wire logic   clock,
   input  wire logic   reset,
   q15fc_req_if.sink   req_ch,
   output logic        cmd_valid,
   output cmd_type     cmd,
   input  wire logic   cmd_ready
);

   localparam int PtrWidth = (QueueDepth > 1) ? $clog2(QueueDepth) : 1;
   localparam int CntWidth = $clog2(QueueDepth + 1);

   cmd_type               q_mem [QueueDepth];
   logic [PtrWidth-1:0]   wr_ptr_ff, wr_ptr_in;
   logic [PtrWidth-1:0]   rd_ptr_ff, rd_ptr_in;
   logic [CntWidth-1:0]   count_ff, count_in;
   cmd_type               cls;
   logic                  drop;
   logic                  push;
   logic                  pop;

   always_comb begin
      cls.index = req_ch.coef_index;
      cls.value = req_ch.value;
      if (req_ch.operation == OP_LOAD) begin
         cls.kind = KIND_LOAD;
      end else if (req_ch.last_sample) begin
         cls.kind = KIND_FINAL;
      end else begin
         cls.kind = KIND_SAMPLE;
      end
      // loads beyond the coefficient store are taken and discarded
      drop = (req_ch.operation == OP_LOAD) &&
             (TapWidth'(req_ch.coef_index) >= TapWidth'(MAX_TAPS));
   end

   assign req_ch.ready = (count_ff != CntWidth'(QueueDepth));
   assign push         = req_ch.valid && req_ch.ready && !drop;
   assign cmd_valid    = (count_ff != '0);
   assign pop          = cmd_valid && cmd_ready;
   assign cmd          = q_mem[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (push) begin
         wr_ptr_in = (wr_ptr_ff == PtrWidth'(QueueDepth - 1)) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (pop) begin
         rd_ptr_in = (rd_ptr_ff == PtrWidth'(QueueDepth - 1)) ? '0 : rd_ptr_ff + 1'b1;
      end
      if (push && !pop) begin
         count_in = count_ff + 1'b1;
      end else if (pop && !push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         q_mem[wr_ptr_ff] <= cls;
      end
   end

endmodule

`default_nettype wire

// File: rtl/q15fc_back.sv
// q15fc_back: coefficient and history stores, shared Q15 MAC and result register.
// Depends on q15fc_pkg and q15fc_rsp_if.
`timescale 1ns / 1ps
`default_nettype none

module q15fc_back import q15fc_pkg::*; #(
   parameter int MAX_TAPS = MaxTapsDefault
) (
   input  wire logic                clock,
   input  wire logic                reset,
   input  wire logic                csr_wr_en,
   input  wire logic [TapWidth-1:0] csr_wr_data,
   input  wire logic                cmd_valid,
   input  wire cmd_type             cmd,
   output logic                     cmd_ready,
   q15fc_rsp_if.source              rsp_ch
);

   localparam int AW = (MAX_TAPS > 1) ? $clog2(MAX_TAPS) : 1;

   back_state_type state_ff, state_in;

   logic [TapWidth-1:0] tap_count_ff;
   logic [TapWidth-1:0] taps_use;
   logic [TapWidth-1:0] taps_ff, taps_in;
   logic [TapWidth-1:0] tail_ff, tail_in;
   logic                last_ff, last_in;
   logic [AW-1:0]       head_ff, head_in;
   logic [AW-1:0]       tap_ix_ff, tap_ix_in;
   logic [AW-1:0]       head_dec;
   logic [AW:0]         rd_sum;
   logic [AW-1:0]       hist_rd_addr;

   logic signed [ValueWidth-1:0] coef_mem [MAX_TAPS];
   logic signed [ValueWidth-1:0] hist_mem [MAX_TAPS];
   logic [MAX_TAPS-1:0]          hist_vld_ff;

   logic                         coef_we;
   logic                         hist_we;
   logic [AW-1:0]                hist_wr_addr;
   logic signed [ValueWidth-1:0] hist_wr_data;
   logic                         hist_wr_vld;
   logic                         hist_clear;
   logic                         issue;
   logic                         acc_clr;
   logic                         out_free;
   logic                         out_load;

   logic                         rd_vld_ff;
   logic signed [ValueWidth-1:0] coef_rd_ff;
   logic signed [ValueWidth-1:0] hist_rd_ff;
   logic                         hist_ok_ff;
   logic signed [ValueWidth-1:0] mul_b;
   logic signed [ProdWidth-1:0]  mul_full;
   logic signed [ProdWidth-1:0]  prod_next;
   logic                         prod_vld_ff;
   logic signed [ProdWidth-1:0]  prod_ff;
   logic signed [SumWidth-1:0]   acc_ff;

   logic                         rsp_valid_ff;
   logic signed [SumWidth-1:0]   rsp_sum_ff;
   logic                         rsp_last_ff;

   // tap count in force: zero reads as one, overrange clips to the store depth
   always_comb begin
      if (tap_count_ff == '0) begin
         taps_use = TapWidth'(1);
      end else if (tap_count_ff > TapWidth'(MAX_TAPS)) begin
         taps_use = TapWidth'(MAX_TAPS);
      end else begin
         taps_use = tap_count_ff;
      end
   end

   // circular history: head is the newest sample, tap j lives at head + j
   assign head_dec = (head_ff == '0) ? AW'(MAX_TAPS - 1) : head_ff - 1'b1;
   assign rd_sum   = {1'b0, head_ff} + {1'b0, tap_ix_ff};
   assign hist_rd_addr = (rd_sum >= (AW + 1)'(MAX_TAPS)) ?
                         AW'(rd_sum - (AW + 1)'(MAX_TAPS)) : rd_sum[AW-1:0];

   assign out_free = !rsp_valid_ff || rsp_ch.ready;

   always_comb begin
      state_in     = state_ff;
      taps_in      = taps_ff;
      tail_in      = tail_ff;
      last_in      = last_ff;
      head_in      = head_ff;
      tap_ix_in    = tap_ix_ff;
      cmd_ready    = 1'b0;
      coef_we      = 1'b0;
      hist_we      = 1'b0;
      hist_wr_addr = head_dec;
      hist_wr_data = cmd.value;
      hist_wr_vld  = 1'b1;
      hist_clear   = 1'b0;
      issue        = 1'b0;
      acc_clr      = 1'b0;
      out_load     = 1'b0;
      unique case (state_ff)
         BACK_IDLE: begin
            cmd_ready = 1'b1;
            if (cmd_valid) begin
               if (cmd.kind == KIND_LOAD) begin
                  coef_we = 1'b1;
               end else begin
                  hist_we   = 1'b1;
                  head_in   = head_dec;
                  acc_clr   = 1'b1;
                  tap_ix_in = '0;
                  taps_in   = taps_use;
                  last_in   = (cmd.kind == KIND_FINAL);
                  tail_in   = (cmd.kind == KIND_FINAL) ? taps_use - 1'b1 : '0;
                  state_in  = BACK_RUN;
               end
            end
         end
         BACK_RUN: begin
            issue = 1'b1;
            if (TapWidth'(tap_ix_ff) == taps_ff - 1'b1) begin
               state_in = BACK_FLUSH;
            end else begin
               tap_ix_in = tap_ix_ff + 1'b1;
            end
         end
         BACK_FLUSH: begin
            if (!rd_vld_ff && !prod_vld_ff) begin
               state_in = BACK_EMIT;
            end
         end
         BACK_EMIT: begin
            if (out_free) begin
               out_load = 1'b1;
               if (tail_ff != '0) begin
                  // tail output: shift a zero in
                  hist_we      = 1'b1;
                  hist_wr_data = '0;
                  hist_wr_vld  = 1'b0;
                  head_in      = head_dec;
                  acc_clr      = 1'b1;
                  tap_ix_in    = '0;
                  tail_in      = tail_ff - 1'b1;
                  state_in     = BACK_RUN;
               end else begin
                  hist_clear = last_ff;
                  state_in   = BACK_IDLE;
               end
            end
         end
         default: begin
            state_in = BACK_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= BACK_IDLE;
         tap_count_ff <= TapWidth'(1);
         head_ff      <= '0;
         hist_vld_ff  <= '0;
         rd_vld_ff    <= 1'b0;
         prod_vld_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff    <= state_in;
         head_ff     <= head_in;
         rd_vld_ff   <= issue;
         prod_vld_ff <= rd_vld_ff;
         if (csr_wr_en) begin
            tap_count_ff <= csr_wr_data;
         end
         if (hist_clear) begin
            hist_vld_ff <= '0;
         end else if (hist_we) begin
            hist_vld_ff[hist_wr_addr] <= hist_wr_vld;
         end
         if (out_load) begin
            rsp_valid_ff <= 1'b1;
         end else if (rsp_ch.ready) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      taps_ff   <= taps_in;
      tail_ff   <= tail_in;
      last_ff   <= last_in;
      tap_ix_ff <= tap_ix_in;
   end

   // stores
   always_ff @(posedge clock) begin
      if (coef_we) begin
         coef_mem[cmd.index[AW-1:0]] <= cmd.value;
      end
      if (hist_we) begin
         hist_mem[hist_wr_addr] <= hist_wr_data;
      end
   end

   // read stage
   always_ff @(posedge clock) begin
      coef_rd_ff <= coef_mem[tap_ix_ff];
      hist_rd_ff <= hist_mem[hist_rd_addr];
      hist_ok_ff <= hist_vld_ff[hist_rd_addr];
   end

   // multiply stage: doubled Q15 product, only -1 * -1 saturates
   assign mul_b    = hist_ok_ff ? hist_rd_ff : '0;
   assign mul_full = ProdWidth'(coef_rd_ff) * ProdWidth'(mul_b);
   always_comb begin
      if ((coef_rd_ff == {1'b1, {(ValueWidth - 1){1'b0}}}) &&
          (mul_b == {1'b1, {(ValueWidth - 1){1'b0}}})) begin
         prod_next = {1'b0, {(ProdWidth - 1){1'b1}}};
      end else begin
         prod_next = mul_full <<< 1;
      end
   end

   always_ff @(posedge clock) begin
      prod_ff <= prod_next;
   end

   // accumulate stage
   always_ff @(posedge clock) begin
      if (acc_clr) begin
         acc_ff <= '0;
      end else if (prod_vld_ff) begin
         acc_ff <= acc_ff + SumWidth'(prod_ff);
      end
   end

   always_ff @(posedge clock) begin
      if (out_load) begin
         rsp_sum_ff  <= acc_ff;
         rsp_last_ff <= last_ff && (tail_ff == '0);
      end
   end

   assign rsp_ch.valid       = rsp_valid_ff;
   assign rsp_ch.sum         = rsp_sum_ff;
   assign rsp_ch.last_output = rsp_last_ff;

endmodule

`default_nettype wire

// File: rtl/q15_full_convolution_top.sv
// q15_full_convolution_top: Q15 full linear convolution, front queue plus MAC back end.
// Depends on q15fc_pkg, q15fc_if, q15fc_front and q15fc_back.
//
//   channel   direction  transaction
//   req_ch    in         load one coefficient, or push one sample (last_sample ends a run)
//   rsp_ch    out        one Q31-scaled output sum, last_output on a run's final output
//   csr_*     in         write tap_count (used as 1..MAX_TAPS), one register, no read-back
//
// Sequence: a load is written to the coefficient store while the back end is idle.
// A sample's output first shifts the history, then issues tap_count reads through the
// single shared MAC, drains the read, multiply and accumulate stages and hands over to
// the output register. Each tail output repeats the reads and the drain, its zero shift
// sharing the hand-over cycle. A final sample gives tap_count outputs.
// Reset: synchronous, active high; clears the history valid bits, tap_count to one and
// the state, head, pipeline valids and queue. Coefficients are undefined until loaded.
// Stalls: a two-entry queue lets the front take transactions while the back end
// computes; a waiting result blocks only the hand-over of the next one.
`timescale 1ns / 1ps
`default_nettype none

module q15_full_convolution_top import q15fc_pkg::*; #(
   parameter int MAX_TAPS = MaxTapsDefault
) (
   input  wire logic                clock,
   input  wire logic                reset,
   input  wire logic                csr_wr_en,
   input  wire logic [TapWidth-1:0] csr_wr_data,
   q15fc_req_if.sink                req_ch,
   q15fc_rsp_if.source              rsp_ch
);

   // queued command between front and back
   logic    cmd_valid;
   logic    cmd_ready;
   cmd_type cmd;

   q15fc_front #(
      .MAX_TAPS (MAX_TAPS)
   ) u_front (
      .clock     (clock),
      .reset     (reset),
      .req_ch    (req_ch),
      .cmd_valid (cmd_valid),
      .cmd       (cmd),
      .cmd_ready (cmd_ready)
   );

   // back end owns tap_count, both stores, the MAC and the result register
   q15fc_back #(
      .MAX_TAPS (MAX_TAPS)
   ) u_back (
      .clock       (clock),
      .reset       (reset),
      .csr_wr_en   (csr_wr_en),
      .csr_wr_data (csr_wr_data),
      .cmd_valid   (cmd_valid),
      .cmd         (cmd),
      .cmd_ready   (cmd_ready),
      .rsp_ch      (rsp_ch)
   );

endmodule

`default_nettype wire

// File: tb/tb_q15_full_convolution_top.sv
// Self-checking testbench for q15_full_convolution_top: coefficient loads, sample streams,
// tail flushes and tap_count settings, checked against an in-bench convolution predictor.
// Depends on q15fc_pkg, q15fc_if and the RTL top level.
`timescale 1ns / 1ps

module tb_q15_full_convolution_top;
   import q15fc_pkg::*;

   localparam int ClockHalf    = 5;
   localparam int ResetCycles  = 8;
   localparam int CycleLimit   = 10_000_000;   // watchdog limit, with plenty of slack
   localparam int SettleCycles = MaxTapsDefault + 16; // one output's worth of back-end work
   localparam int HoldCycles   = 300;
   localparam int NoisyItems   = 350;          // transaction count where idling stops
   localparam int TotalItems   = 410;

   typedef struct {
      logic signed [SumWidth-1:0] sum;
      logic                       last_output;
   } conv_output_type;

   logic                clock = 1'b0;
   logic                reset;
   logic                csr_wr_en;
   logic [TapWidth-1:0] csr_wr_data;

   q15fc_req_if req_ch ();
   q15fc_rsp_if rsp_ch ();

   q15_full_convolution_top #(
      .MAX_TAPS (MaxTapsDefault)
   ) uut (
      .clock       (clock),
      .reset       (reset),
      .csr_wr_en   (csr_wr_en),
      .csr_wr_data (csr_wr_data),
      .req_ch      (req_ch),
      .rsp_ch      (rsp_ch)
   );

   // ---------------------------------------------------------------------------------
   // Predictor state: our own copy of the coefficient store, delay line and tap count
   // ---------------------------------------------------------------------------------
   logic signed [ValueWidth-1:0] coef_mirror    [MaxTapsDefault];
   logic signed [ValueWidth-1:0] history_mirror [MaxTapsDefault];
   logic [TapWidth-1:0]          taps_mirror;
   conv_output_type              pending_outputs[$];

   int  error_count     = 0;
   int  items_sent      = 0;
   int  outputs_checked = 0;
   int  cycle_count     = 0;
   bit  idle_on         = 1'b1;   // random gaps on both channels
   bit  hold_request    = 1'b0;   // asks the receiver for one long hold-off

   always begin
      clock = 1'b0;
      #ClockHalf;
      clock = 1'b1;
      #ClockHalf;
   end

   // Doubled Q15 product; only -1 * -1 saturates
   function automatic longint q15_product(logic signed [ValueWidth-1:0] a,
                                          logic signed [ValueWidth-1:0] b);
      if (a == 16'sh8000 && b == 16'sh8000)
         return 64'sh7FFF_FFFF;
      return longint'(a) * longint'(b) * 2;
   endfunction

   // tap_count as the block applies it: 0 counts as 1, above MAX_TAPS clips
   function automatic int taps_in_effect();
      if (taps_mirror == '0)
         return 1;
      if (taps_mirror > MaxTapsDefault)
         return MaxTapsDefault;
      return int'(taps_mirror);
   endfunction

   // Shift one sample into the delay line and form the next convolution output
   function automatic logic signed [SumWidth-1:0] convolve_next(
         logic signed [ValueWidth-1:0] sample, int taps);
      longint acc;
      int     j;
      for (j = MaxTapsDefault - 1; j > 0; j--)
         history_mirror[j] = history_mirror[j-1];
      history_mirror[0] = sample;
      acc = 0;
      for (j = 0; j < taps; j++)
         acc += q15_product(coef_mirror[j], history_mirror[j]);
      return acc[SumWidth-1:0];
   endfunction

   // Apply one accepted transaction to the mirror and queue the outputs it causes
   function automatic void mirror_transaction(logic op, logic [IndexWidth-1:0] idx,
                                              logic signed [ValueWidth-1:0] val,
                                              logic is_last);
      conv_output_type out;
      int              taps;
      int              k;
      if (op == OP_LOAD) begin
         coef_mirror[idx] = val;   // last_sample has no meaning on a load
         return;
      end
      taps            = taps_in_effect();
      out.sum         = convolve_next(val, taps);
      out.last_output = is_last && (taps == 1);
      pending_outputs.push_back(out);
      if (is_last) begin
         // tail: zeros shifted in until every product has left the window
         for (k = 1; k < taps; k++) begin
            out.sum         = convolve_next('0, taps);
            out.last_output = (k == taps - 1);
            pending_outputs.push_back(out);
         end
         for (k = 0; k < MaxTapsDefault; k++)
            history_mirror[k] = '0;
      end
   endfunction

   task automatic report_mismatch(string what, longint want, longint got);
      error_count++;
      $display("MISMATCH %0s: expected %0d, got %0d (cycle %0d)",
               what, want, got, cycle_count);
   endtask

   // ---------------------------------------------------------------------------------
   // Result checking: every accepted output against the oldest prediction
   // ---------------------------------------------------------------------------------
   always @(posedge clock) begin
      conv_output_type want;
      if (!reset && rsp_ch.valid && rsp_ch.ready) begin
         outputs_checked++;
         if (pending_outputs.size() == 0) begin
            report_mismatch("output with nothing pending", 0, longint'(rsp_ch.sum));
         end else begin
            want = pending_outputs.pop_front();
            if (rsp_ch.sum !== want.sum)
               report_mismatch("sum", longint'(want.sum), longint'(rsp_ch.sum));
            if (rsp_ch.last_output !== want.last_output)
               report_mismatch("last_output", longint'(want.last_output),
                               longint'(rsp_ch.last_output));
         end
      end
   end

   // ---------------------------------------------------------------------------------
   // Receiver: random stall bursts, plus one long hold-off counted here
   // ---------------------------------------------------------------------------------
   initial begin
      int hold_left;
      int burst_left;
      hold_left    = 0;
      burst_left   = 0;
      rsp_ch.ready = 1'b0;
      forever begin
         @(negedge clock);
         if (hold_left > 0) begin
            rsp_ch.ready <= 1'b0;
            hold_left--;
         end else if (hold_request) begin
            hold_request = 1'b0;
            hold_left    = HoldCycles - 1;
            rsp_ch.ready <= 1'b0;
         end else if (burst_left > 0) begin
            rsp_ch.ready <= 1'b0;
            burst_left--;
         end else if (idle_on && $urandom_range(0, 7) == 0) begin
            burst_left   = $urandom_range(1, 6) - 1;
            rsp_ch.ready <= 1'b0;
         end else begin
            rsp_ch.ready <= 1'b1;
         end
      end
   end

   // Watchdog: a hung handshake ends the run here
   initial begin
      while (cycle_count < CycleLimit) begin
         @(posedge clock);
         cycle_count++;
      end
      $display("Timed out after %0d cycles, %0d outputs still pending",
               cycle_count, pending_outputs.size());
      $display("tb_q15_full_convolution_top NOT OK");
      $finish;
   end

   // ---------------------------------------------------------------------------------
   // Sender side
   // ---------------------------------------------------------------------------------

   // One transaction: optional gap, drive at the falling edge, hold until accepted.
   // valid stays high on return so back-to-back transactions need no re-raise.
   task automatic send_transaction(logic op, logic [IndexWidth-1:0] idx,
                                   logic signed [ValueWidth-1:0] val, logic is_last);
      int gap;
      if (idle_on && $urandom_range(0, 4) == 0) begin
         gap = $urandom_range(1, 6);
         @(negedge clock);
         req_ch.valid <= 1'b0;
         repeat (gap - 1) @(negedge clock);
      end
      @(negedge clock);
      req_ch.valid       <= 1'b1;
      req_ch.operation   <= op;
      req_ch.coef_index  <= idx;
      req_ch.value       <= val;
      req_ch.last_sample <= is_last;
      @(posedge clock);
      while (!req_ch.ready)
         @(posedge clock);
      items_sent++;
      mirror_transaction(op, idx, val, is_last);
   endtask

   task automatic send_sample(logic signed [ValueWidth-1:0] val, logic is_last);
      send_transaction(OP_SAMPLE, IndexWidth'($urandom), val, is_last);
   endtask

   // Drop valid, wait for every predicted output, then let a trailing load settle
   task automatic wait_until_drained();
      @(negedge clock);
      req_ch.valid <= 1'b0;
      while (pending_outputs.size() != 0)
         @(posedge clock);
      repeat (SettleCycles) @(posedge clock);
   endtask

   // tap_count is only written with the block idle
   task automatic set_tap_count(logic [TapWidth-1:0] taps);
      wait_until_drained();
      @(negedge clock);
      csr_wr_en   <= 1'b1;
      csr_wr_data <= taps;
      taps_mirror  = taps;
      @(negedge clock);
      csr_wr_en   <= 1'b0;
   endtask

   // Sample values biased towards the corners of Q15
   function automatic logic signed [ValueWidth-1:0] pick_value();
      case ($urandom_range(0, 9))
         0:       return 16'sh8000;
         1:       return 16'sh7FFF;
         2:       return '0;
         3:       return -16'sd1;
         default: return ValueWidth'($urandom);
      endcase
   endfunction

   // ---------------------------------------------------------------------------------
   // Tests
   // ---------------------------------------------------------------------------------

   // Fill every slot first, so no sample ever reads an unwritten coefficient.
   // The corners sit in slots 0 to 2; slot 0 is used by every tap count.
   task automatic test_coefficient_load();
      int i;
      logic signed [ValueWidth-1:0] c;
      for (i = 0; i < MaxTapsDefault; i++) begin
         case (i)
            0:       c = 16'sh8000;
            1:       c = 16'sh7FFF;
            2:       c = -16'sd1;
            default: c = ValueWidth'($urandom);
         endcase
         // last_sample set on odd loads, ignored
         send_transaction(OP_LOAD, IndexWidth'(i), c, i[0]);
      end
   endtask

   // tap_count is still at its reset value of one here
   task automatic test_reset_tap_count();
      send_sample(16'sh8000, 1'b0);   // -1 * -1 saturates
      send_sample(16'sh7FFF, 1'b0);
      send_sample('0, 1'b0);
      send_sample(16'sh8000, 1'b1);   // single tap: the sample's own output is the last
   endtask

   // Short sequence with a tail, and a load with last_sample set in the middle
   task automatic test_tail_flush();
      set_tap_count(TapWidth'(3));
      send_sample(16'sh7FFF, 1'b0);
      send_transaction(OP_LOAD, 6'd3, 16'sh1234, 1'b1);
      send_sample(16'sh8000, 1'b0);
      send_sample(16'sd1, 1'b1);
   endtask

   // Zero counts as one; anything above the maximum clips to the maximum
   task automatic test_tap_count_limits();
      set_tap_count('0);
      send_sample(16'sh7FFF, 1'b1);
      set_tap_count('1);
      send_sample(16'sh8000, 1'b0);
      send_sample(16'sh7FFF, 1'b1);
      set_tap_count(TapWidth'(MaxTapsDefault));
      send_sample(16'sh8000, 1'b1);
   endtask

   // New count takes effect from the next sample; the delay line is kept
   task automatic test_tap_change_mid_sequence();
      set_tap_count(TapWidth'(4));
      send_sample(16'sh4000, 1'b0);
      send_sample(-16'sd1, 1'b0);
      send_sample(16'sh8000, 1'b0);
      set_tap_count(TapWidth'(7));
      send_sample(16'sh7FFF, 1'b0);
      send_sample(16'sh0101, 1'b1);
   endtask

   // Receiver holds off while the sender keeps offering, so the queue fills and
   // the input stalls
   task automatic test_output_hold_off();
      int i;
      set_tap_count(TapWidth'(2));
      idle_on      = 1'b0;
      hold_request = 1'b1;
      for (i = 0; i < 10; i++)
         send_sample(pick_value(), i == 9);
      idle_on = 1'b1;
   endtask

   // Random phases: a tap count, then a sample sequence with loads mixed in.
   // Most sequences close with a last sample; some stay open into the next phase.
   task automatic test_random_sequences(int stop_at);
      int                  pick;
      int                  len;
      int                  k;
      logic [TapWidth-1:0] taps;
      while (items_sent < stop_at) begin
         pick = $urandom_range(0, 99);
         if (pick < 65)      taps = TapWidth'($urandom_range(1, 8));
         else if (pick < 80) taps = TapWidth'($urandom_range(9, MaxTapsDefault - 1));
         else if (pick < 87) taps = TapWidth'(MaxTapsDefault);
         else if (pick < 93) taps = '0;
         else                taps = TapWidth'($urandom_range(MaxTapsDefault + 1, 127));
         set_tap_count(taps);
         len = $urandom_range(1, 16);
         for (k = 0; k < len; k++) begin
            if ($urandom_range(0, 6) == 0)
               send_transaction(OP_LOAD, IndexWidth'($urandom), pick_value(),
                                1'($urandom));
            if ($urandom_range(0, 29) == 0)
               wait_until_drained();   // sender pauses until all outputs are in
            send_sample(pick_value(), (k == len - 1) && ($urandom_range(0, 9) != 0));
         end
      end
   endtask

   // ---------------------------------------------------------------------------------
   // Main sequence
   // ---------------------------------------------------------------------------------
   initial begin
      int i;
      for (i = 0; i < MaxTapsDefault; i++) begin
         coef_mirror[i]    = '0;
         history_mirror[i] = '0;
      end
      taps_mirror        = TapWidth'(1);
      reset              = 1'b1;
      csr_wr_en          = 1'b0;
      csr_wr_data        = '0;
      req_ch.valid       = 1'b0;
      req_ch.operation   = OP_LOAD;
      req_ch.coef_index  = '0;
      req_ch.value       = '0;
      req_ch.last_sample = 1'b0;
      repeat (ResetCycles) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      test_coefficient_load();
      test_reset_tap_count();
      test_tail_flush();
      test_tap_count_limits();
      test_tap_change_mid_sequence();
      test_output_hold_off();
      test_random_sequences(NoisyItems);
      idle_on = 1'b0;                 // closing stretch runs flat out
      test_random_sequences(TotalItems);
      wait_until_drained();

      $display("Ran %0d transactions (loads and samples), checked %0d outputs in %0d cycles",
               items_sent, outputs_checked, cycle_count);
      $display("Tap counts 0 to 127, tail flushes, mid-sequence changes, long output hold-off");
      if (error_count == 0) begin
         $display("tb_q15_full_convolution_top OK");
      end else begin
         $display("tb_q15_full_convolution_top NOT OK");
      end
      $finish;
   end

endmodule

// File: filelist.f
rtl/q15fc_pkg.sv
rtl/q15fc_if.sv
rtl/q15fc_front.sv
rtl/q15fc_back.sv
rtl/q15_full_convolution_top.sv
tb/tb_q15_full_convolution_top.sv
